// ----- rtl/usg_pkg.sv -----
// ----------------------------------------------------------------------------
// usg_pkg
// Shared constants, types and tables for the UV sphere tile generator.
// ----------------------------------------------------------------------------
package usg_pkg;

  localparam int FRAC_BITS    = 14;
  localparam int MAX_DIV      = 1024;
  localparam int CNT_W        = 11;
  localparam int IDX_W        = 10;
  localparam int POS_W        = 15;
  localparam int NORM_W       = 16;

  // Phase division: numerator (k << shift) + n/2, restoring, bit per step
  localparam int POLAR_SHIFT  = 31;
  localparam int AZ_SHIFT     = 32;
  localparam int NUM_W        = 44;
  localparam int REM_W        = CNT_W;
  localparam int DIV_PER_STG  = 4;
  localparam int DIV_STAGES   = NUM_W / DIV_PER_STG;
  localparam int PHASE_W      = 32;

  // CORDIC rotation
  localparam int CORDIC_STEPS = 24;
  localparam int COR_PER_STG  = 2;
  localparam int COR_STAGES   = CORDIC_STEPS / COR_PER_STG;
  localparam int CW           = 34;
  localparam int TRIG_W       = 32;
  localparam int PROD_W       = 2 * TRIG_W;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // Register stages of a lane, from its input register through its sin/cos
  // output register
  localparam int LANE_LAT     = DIV_STAGES + COR_STAGES + 3;

  localparam int NUM_LANES    = 4;
  localparam int NUM_CORNERS  = 4;
  localparam int VCNT_W       = 3;
  localparam logic [VCNT_W-1:0] VTX_LAST = 3'd5;

  localparam logic [CNT_W-1:0] CNT_RESET = 11'd16;

  typedef enum logic [0:0] {
    REG_BAND  = 1'b0,
    REG_WEDGE = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BL = 2'd2,
    CORNER_BR = 2'd3
  } corner_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
  } vertex_t;

  // Arctangent of 2^-k in phase units (2^32 per turn)
  function automatic logic signed [CW-1:0] atan_phase(input int k);
    logic signed [CW-1:0] a;
    case (k)
      0:  a = 34'sd536870912;
      1:  a = 34'sd316933406;
      2:  a = 34'sd167458907;
      3:  a = 34'sd85004756;
      4:  a = 34'sd42667331;
      5:  a = 34'sd21354465;
      6:  a = 34'sd10679838;
      7:  a = 34'sd5340245;
      8:  a = 34'sd2670163;
      9:  a = 34'sd1335087;
      10: a = 34'sd667544;
      11: a = 34'sd333772;
      12: a = 34'sd166886;
      13: a = 34'sd83443;
      14: a = 34'sd41722;
      15: a = 34'sd20861;
      16: a = 34'sd10430;
      17: a = 34'sd5215;
      18: a = 34'sd2608;
      19: a = 34'sd1304;
      20: a = 34'sd652;
      21: a = 34'sd326;
      22: a = 34'sd163;
      23: a = 34'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/usg_sincos_lane.sv -----
// ----------------------------------------------------------------------------
// usg_sincos_lane
// Pipelined phase divider followed by a pipelined CORDIC: turns a division
// numerator and count into the sine and cosine of the rounded phase.
// ----------------------------------------------------------------------------
module usg_sincos_lane (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic        [usg_pkg::NUM_W-1:0]       num,
  input  logic        [usg_pkg::CNT_W-1:0]       den,
  output logic signed [usg_pkg::TRIG_W-1:0]      sin_val,
  output logic signed [usg_pkg::TRIG_W-1:0]      cos_val
);

  localparam int DS = usg_pkg::DIV_STAGES;
  localparam int CS = usg_pkg::COR_STAGES;
  localparam int CW = usg_pkg::CW;

  logic        [usg_pkg::REM_W-1:0] rem_r [0:DS];
  logic        [usg_pkg::NUM_W-1:0] quo_r [0:DS];
  logic        [usg_pkg::CNT_W-1:0] den_r [0:DS];
  logic        [usg_pkg::REM_W-1:0] rem_nxt [1:DS];
  logic        [usg_pkg::NUM_W-1:0] quo_nxt [1:DS];

  logic signed [CW-1:0] cx_r [0:CS];
  logic signed [CW-1:0] cy_r [0:CS];
  logic signed [CW-1:0] cz_r [0:CS];
  logic        [1:0]    cq_r [0:CS];
  logic signed [CW-1:0] cx_nxt [1:CS];
  logic signed [CW-1:0] cy_nxt [1:CS];
  logic signed [CW-1:0] cz_nxt [1:CS];

  logic [usg_pkg::PHASE_W-1:0] ph;
  logic [usg_pkg::PHASE_W-1:0] ph_bias;
  logic [usg_pkg::PHASE_W-1:0] ph_res;
  logic [1:0]                  quad;

  logic signed [usg_pkg::TRIG_W-1:0] sin_nxt;
  logic signed [usg_pkg::TRIG_W-1:0] cos_nxt;

  function automatic logic signed [CW-1:0] shr_trunc(input logic signed [CW-1:0] v,
                                                     input int k);
    logic signed [CW-1:0] r;
    if (v[CW-1]) begin
      r = -((-v) >>> k);
    end else begin
      r = v >>> k;
    end
    return r;
  endfunction

  // Restoring division, four quotient bits per stage
  always_comb begin
    logic [usg_pkg::REM_W:0]   part;
    logic [usg_pkg::REM_W-1:0] rem_v;
    logic [usg_pkg::NUM_W-1:0] quo_v;
    for (int s = 0; s < DS; s++) begin
      rem_v = rem_r[s];
      quo_v = quo_r[s];
      for (int b = 0; b < usg_pkg::DIV_PER_STG; b++) begin
        part = {rem_v, quo_v[usg_pkg::NUM_W-1]};
        if (part >= {1'b0, den_r[s]}) begin
          rem_v = usg_pkg::REM_W'(part - {1'b0, den_r[s]});
          quo_v = {quo_v[usg_pkg::NUM_W-2:0], 1'b1};
        end else begin
          rem_v = part[usg_pkg::REM_W-1:0];
          quo_v = {quo_v[usg_pkg::NUM_W-2:0], 1'b0};
        end
      end
      rem_nxt[s+1] = rem_v;
      quo_nxt[s+1] = quo_v;
    end
  end

  // Quadrant fold: residual lands in [-1/8, 1/8) of a turn
  assign ph      = quo_r[DS][usg_pkg::PHASE_W-1:0];
  assign ph_bias = ph + 32'h2000_0000;
  assign quad    = ph_bias[usg_pkg::PHASE_W-1:usg_pkg::PHASE_W-2];
  assign ph_res  = ph - {quad, 30'd0};

  // Two micro-rotations per stage
  always_comb begin
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] nx;
    for (int s = 0; s < CS; s++) begin
      x = cx_r[s];
      y = cy_r[s];
      z = cz_r[s];
      for (int t = 0; t < usg_pkg::COR_PER_STG; t++) begin
        if (!z[CW-1]) begin
          nx = x - shr_trunc(y, s * usg_pkg::COR_PER_STG + t);
          y  = y + shr_trunc(x, s * usg_pkg::COR_PER_STG + t);
          z  = z - usg_pkg::atan_phase(s * usg_pkg::COR_PER_STG + t);
        end else begin
          nx = x + shr_trunc(y, s * usg_pkg::COR_PER_STG + t);
          y  = y - shr_trunc(x, s * usg_pkg::COR_PER_STG + t);
          z  = z + usg_pkg::atan_phase(s * usg_pkg::COR_PER_STG + t);
        end
        x = nx;
      end
      cx_nxt[s+1] = x;
      cy_nxt[s+1] = y;
      cz_nxt[s+1] = z;
    end
  end

  // Unfold the quadrant
  always_comb begin
    logic signed [usg_pkg::TRIG_W-1:0] xf;
    logic signed [usg_pkg::TRIG_W-1:0] yf;
    xf = cx_r[CS][usg_pkg::TRIG_W-1:0];
    yf = cy_r[CS][usg_pkg::TRIG_W-1:0];
    case (cq_r[CS])
      2'd0: begin
        cos_nxt = xf;
        sin_nxt = yf;
      end
      2'd1: begin
        cos_nxt = -yf;
        sin_nxt = xf;
      end
      2'd2: begin
        cos_nxt = -xf;
        sin_nxt = -yf;
      end
      default: begin
        cos_nxt = yf;
        sin_nxt = -xf;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      quo_r[0] <= num;
      den_r[0] <= den;
      for (int s = 1; s <= DS; s++) begin
        rem_r[s] <= rem_nxt[s];
        quo_r[s] <= quo_nxt[s];
        den_r[s] <= den_r[s-1];
      end
      cx_r[0] <= usg_pkg::CORDIC_GAIN;
      cy_r[0] <= '0;
      cz_r[0] <= {{(CW-usg_pkg::PHASE_W){ph_res[usg_pkg::PHASE_W-1]}}, ph_res};
      cq_r[0] <= quad;
      for (int s = 1; s <= CS; s++) begin
        cx_r[s] <= cx_nxt[s];
        cy_r[s] <= cy_nxt[s];
        cz_r[s] <= cz_nxt[s];
        cq_r[s] <= cq_r[s-1];
      end
      sin_val <= sin_nxt;
      cos_val <= cos_nxt;
    end
  end

endmodule

// ----- rtl/uv_sphere_tile_generator.sv -----
// ----------------------------------------------------------------------------
// uv_sphere_tile_generator
// Path: an accepted tile passes the clamp, lane, multiply, round and hold registers.
// Throughput: one vertex per cycle while out_ready is high; every stage before
//   the output stalls with the hold stage until its sixth vertex is taken.
// Reset (rst_n, synchronous): clears all valid bits and the vertex counter,
//   and sets the band and wedge counts (band_r, wedge_r) to 16.
// ----------------------------------------------------------------------------
//
// Emits the six vertices of one UV sphere tile (two triangles), each with a
// Q1.14 position on a radius one half sphere and its unit normal.
//
// Pipeline, all stages advancing together on one enable:
//   clamp  : clamp counts to 1..1024 and indices to count-1
//   lanes  : four identical sin/cos lanes, polar i, polar i+1, azimuth j,
//            azimuth j+1. Each lane divides (k << shift) + n/2 by n over
//            11 stages (4 quotient bits each), folds the phase to a quadrant,
//            then runs a 24-step CORDIC over 12 stages (2 steps each).
//   mult   : sin(phi) * cos(theta) and sin(phi) * sin(theta) per corner
//   round  : round half up and saturate position and normal per corner
//   hold   : the four corners of the tile; a counter walks the output order
//            TR, BR, BL, BL, TL, TR and flags the sixth vertex.
//
// The pipeline advances whenever the hold stage is empty or its sixth vertex
// is being taken, so no new tile enters while a held tile has vertices left.
module uv_sphere_tile_generator (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic        [usg_pkg::IDX_W-1:0]    in_wedge_index,
  input  logic        [usg_pkg::IDX_W-1:0]    in_band_index,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [usg_pkg::POS_W-1:0]    out_pos_x,
  output logic signed [usg_pkg::POS_W-1:0]    out_pos_y,
  output logic signed [usg_pkg::POS_W-1:0]    out_pos_z,
  output logic signed [usg_pkg::NORM_W-1:0]   out_norm_x,
  output logic signed [usg_pkg::NORM_W-1:0]   out_norm_y,
  output logic signed [usg_pkg::NORM_W-1:0]   out_norm_z,
  output logic                                out_last_vertex,

  input  logic                                cfg_we,
  input  logic        [0:0]                   cfg_index,
  input  logic        [usg_pkg::CNT_W-1:0]    cfg_data
);

  localparam int LAT = usg_pkg::LANE_LAT;
  localparam int NL  = usg_pkg::NUM_LANES;
  localparam int NC  = usg_pkg::NUM_CORNERS;
  localparam int LIM_POS  = 1 << (usg_pkg::FRAC_BITS - 1);
  localparam int LIM_NORM = 1 << usg_pkg::FRAC_BITS;

  // Configuration registers
  logic [usg_pkg::CNT_W-1:0] band_r;
  logic [usg_pkg::CNT_W-1:0] wedge_r;

  // Pipeline advance
  logic adv;

  // Clamp stage
  logic                      va_r;
  logic [usg_pkg::CNT_W-1:0] nb_nxt, nw_nxt, ib_nxt, jw_nxt;
  logic [usg_pkg::CNT_W-1:0] nb_r, nw_r, ib_r, jw_r;
  logic [usg_pkg::CNT_W-1:0] ib_inc, jw_inc;

  // Lanes
  logic        [usg_pkg::NUM_W-1:0]  lane_num [0:NL-1];
  logic        [usg_pkg::CNT_W-1:0]  lane_den [0:NL-1];
  logic signed [usg_pkg::TRIG_W-1:0] lane_sin [0:NL-1];
  logic signed [usg_pkg::TRIG_W-1:0] lane_cos [0:NL-1];
  logic                              lv_r [0:LAT-1];

  // Multiply stage
  logic                              mv_r;
  logic signed [usg_pkg::PROD_W-1:0] prod_x_r [0:NC-1];
  logic signed [usg_pkg::PROD_W-1:0] prod_z_r [0:NC-1];
  logic signed [usg_pkg::TRIG_W-1:0] cp_r     [0:NC-1];

  // Round stage and hold stage
  logic              rv_r;
  usg_pkg::vertex_t  vtx_nxt  [0:NC-1];
  usg_pkg::vertex_t  vtx_r    [0:NC-1];
  logic              hv_r;
  usg_pkg::vertex_t  hold_r   [0:NC-1];
  logic [usg_pkg::VCNT_W-1:0] vcnt_r;
  usg_pkg::corner_t  sel;
  usg_pkg::vertex_t  cur;

  // floor((v + half) / 2^sh), then saturate to +-lim
  function automatic logic signed [15:0] round_sat(input logic signed [63:0] v,
                                                   input int sh, input int lim);
    logic signed [64:0] t;
    logic signed [64:0] lim_s;
    lim_s = 65'(lim);
    t = {v[63], v} + (65'sd1 <<< (sh - 1));
    t = t >>> sh;
    if (t > lim_s) begin
      t = lim_s;
    end else if (t < -lim_s) begin
      t = -lim_s;
    end
    return t[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r  <= usg_pkg::CNT_RESET;
      wedge_r <= usg_pkg::CNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        usg_pkg::REG_BAND:  band_r  <= cfg_data;
        usg_pkg::REG_WEDGE: wedge_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance whenever the hold stage is free or its sixth vertex leaves
  assign adv      = !hv_r || (out_ready && (vcnt_r == usg_pkg::VTX_LAST));
  assign in_ready = adv;

  // ---------------------------------------------------------------------------
  // Clamp stage: counts into 1..MAX_DIV, indices below their count
  // ---------------------------------------------------------------------------
  always_comb begin
    if (band_r == '0) begin
      nb_nxt = usg_pkg::CNT_W'(1);
    end else if (band_r > usg_pkg::CNT_W'(usg_pkg::MAX_DIV)) begin
      nb_nxt = usg_pkg::CNT_W'(usg_pkg::MAX_DIV);
    end else begin
      nb_nxt = band_r;
    end
    if (wedge_r == '0) begin
      nw_nxt = usg_pkg::CNT_W'(1);
    end else if (wedge_r > usg_pkg::CNT_W'(usg_pkg::MAX_DIV)) begin
      nw_nxt = usg_pkg::CNT_W'(usg_pkg::MAX_DIV);
    end else begin
      nw_nxt = wedge_r;
    end
    if ({1'b0, in_band_index} >= nb_nxt) begin
      ib_nxt = nb_nxt - usg_pkg::CNT_W'(1);
    end else begin
      ib_nxt = {1'b0, in_band_index};
    end
    if ({1'b0, in_wedge_index} >= nw_nxt) begin
      jw_nxt = nw_nxt - usg_pkg::CNT_W'(1);
    end else begin
      jw_nxt = {1'b0, in_wedge_index};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nb_r <= nb_nxt;
      nw_r <= nw_nxt;
      ib_r <= ib_nxt;
      jw_r <= jw_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Lane numerators: (k << shift) + n/2; the next index never exceeds 1024
  // ---------------------------------------------------------------------------
  assign ib_inc = ib_r + usg_pkg::CNT_W'(1);
  assign jw_inc = jw_r + usg_pkg::CNT_W'(1);

  assign lane_num[0] = (usg_pkg::NUM_W'(ib_r) << usg_pkg::POLAR_SHIFT)
                       + usg_pkg::NUM_W'(nb_r >> 1);
  assign lane_num[1] = (usg_pkg::NUM_W'(ib_inc) << usg_pkg::POLAR_SHIFT)
                       + usg_pkg::NUM_W'(nb_r >> 1);
  assign lane_num[2] = (usg_pkg::NUM_W'(jw_r) << usg_pkg::AZ_SHIFT)
                       + usg_pkg::NUM_W'(nw_r >> 1);
  assign lane_num[3] = (usg_pkg::NUM_W'(jw_inc) << usg_pkg::AZ_SHIFT)
                       + usg_pkg::NUM_W'(nw_r >> 1);
  assign lane_den[0] = nb_r;
  assign lane_den[1] = nb_r;
  assign lane_den[2] = nw_r;
  assign lane_den[3] = nw_r;

  for (genvar g = 0; g < NL; g++) begin : g_lane
    usg_sincos_lane u_lane (
      .clk     (clk),
      .en      (adv),
      .num     (lane_num[g]),
      .den     (lane_den[g]),
      .sin_val (lane_sin[g]),
      .cos_val (lane_cos[g])
    );
  end

  // Valid bits follow the lane pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < LAT; s++) begin
        lv_r[s] <= 1'b0;
      end
    end else if (adv) begin
      lv_r[0] <= va_r;
      for (int s = 1; s < LAT; s++) begin
        lv_r[s] <= lv_r[s-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Multiply stage: corner c uses polar lane c[1] and azimuth lane 2 + c[0]
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NC; c++) begin
        prod_x_r[c] <= lane_sin[c >> 1] * lane_cos[2 + (c & 1)];
        prod_z_r[c] <= lane_sin[c >> 1] * lane_sin[2 + (c & 1)];
        cp_r[c]     <= lane_cos[c >> 1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Round stage: position is half the value, both rounded on their own
  // ---------------------------------------------------------------------------
  always_comb begin
    logic signed [15:0] px, py, pz;
    logic signed [63:0] cpw;
    for (int c = 0; c < NC; c++) begin
      cpw = {{(usg_pkg::PROD_W - usg_pkg::TRIG_W){cp_r[c][usg_pkg::TRIG_W-1]}}, cp_r[c]};
      px = round_sat(prod_x_r[c], 61 - usg_pkg::FRAC_BITS, LIM_POS);
      py = round_sat(cpw,         31 - usg_pkg::FRAC_BITS, LIM_POS);
      pz = round_sat(prod_z_r[c], 61 - usg_pkg::FRAC_BITS, LIM_POS);
      vtx_nxt[c].pos_x  = px[usg_pkg::POS_W-1:0];
      vtx_nxt[c].pos_y  = py[usg_pkg::POS_W-1:0];
      vtx_nxt[c].pos_z  = pz[usg_pkg::POS_W-1:0];
      vtx_nxt[c].norm_x = round_sat(prod_x_r[c], 60 - usg_pkg::FRAC_BITS, LIM_NORM);
      vtx_nxt[c].norm_y = round_sat(cpw,         30 - usg_pkg::FRAC_BITS, LIM_NORM);
      vtx_nxt[c].norm_z = round_sat(prod_z_r[c], 60 - usg_pkg::FRAC_BITS, LIM_NORM);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < NC; c++) begin
        vtx_r[c]  <= vtx_nxt[c];
        hold_r[c] <= vtx_r[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
      rv_r <= 1'b0;
      hv_r <= 1'b0;
    end else if (adv) begin
      mv_r <= lv_r[LAT-1];
      rv_r <= mv_r;
      hv_r <= rv_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Hold stage: walk the six vertices, restart on each new tile
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r <= '0;
    end else if (adv) begin
      vcnt_r <= '0;
    end else if (out_ready) begin
      vcnt_r <= vcnt_r + usg_pkg::VCNT_W'(1);
    end
  end

  always_comb begin
    case (vcnt_r)
      3'd0:    sel = usg_pkg::CORNER_TR;
      3'd1:    sel = usg_pkg::CORNER_BR;
      3'd2:    sel = usg_pkg::CORNER_BL;
      3'd3:    sel = usg_pkg::CORNER_BL;
      3'd4:    sel = usg_pkg::CORNER_TL;
      default: sel = usg_pkg::CORNER_TR;
    endcase
  end

  assign cur             = hold_r[sel];
  assign out_valid       = hv_r;
  assign out_pos_x       = cur.pos_x;
  assign out_pos_y       = cur.pos_y;
  assign out_pos_z       = cur.pos_z;
  assign out_norm_x      = cur.norm_x;
  assign out_norm_y      = cur.norm_y;
  assign out_norm_z      = cur.norm_z;
  assign out_last_vertex = (vcnt_r == usg_pkg::VTX_LAST);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    (vcnt_r != '0) |-> hv_r)
    else $error("vertex counter moved with no tile held");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vcnt_r <= usg_pkg::VTX_LAST)
    else $error("vertex counter passed the sixth vertex");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_vertex) |=> (vcnt_r == '0))
    else $error("counter did not restart after the last vertex");

  a_stall_holds_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(vcnt_r))
    else $error("vertex counter moved during an output stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> va_r)
    else $error("accepted tile did not enter the clamp stage");

endmodule

// ----- sim/uv_sphere_tile_generator_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uv_sphere_tile_generator_test
// Feeds tile index pairs through the tile generator under several band and
// wedge counts, recomputes every vertex with an in-bench CORDIC predictor and
// compares all six vertices per tile field by field, with random stalls.
// ----------------------------------------------------------------------------
module uv_sphere_tile_generator_test;

  typedef struct packed {
    logic [usg_pkg::IDX_W-1:0] wedge;
    logic [usg_pkg::IDX_W-1:0] band;
  } tile_t;

  typedef struct packed {
    usg_pkg::vertex_t v;
    logic             last;
  } tile_vertex_t;

  localparam longint ATAN_PH [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  logic clk;
  logic rst_n;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [usg_pkg::IDX_W-1:0] in_wedge_index = '0;
  logic [usg_pkg::IDX_W-1:0] in_band_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [usg_pkg::POS_W-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [usg_pkg::NORM_W-1:0] out_norm_x, out_norm_y, out_norm_z;
  logic out_last_vertex;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [usg_pkg::CNT_W-1:0] cfg_data;

  uv_sphere_tile_generator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_wedge_index(in_wedge_index), .in_band_index(in_band_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_norm_x(out_norm_x), .out_norm_y(out_norm_y), .out_norm_z(out_norm_z),
    .out_last_vertex(out_last_vertex),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Bench copy of the count registers, changed only while the block is idle
  logic [usg_pkg::CNT_W-1:0] band_regs;
  logic [usg_pkg::CNT_W-1:0] wedge_regs;

  tile_t        tiles_pending[$];
  tile_vertex_t vertices_due[$];
  int           mismatches = 0;
  int           tiles_taken = 0;
  bit           in_taken = 1'b0;

  // ---------------------------------------------------------------- predictor

  function automatic longint trunc_shift(longint v, int k);
    if (v >= 0) return v >>> k;
    return -((-v) >>> k);
  endfunction

  // Round half up: arithmetic shift of a signed value is already a floor
  function automatic longint round_half_up(longint v, int s);
    v = v + (longint'(1) << (s - 1));
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic [31:0] turn_phase(longint unsigned k, longint unsigned n,
                                             int shift);
    longint unsigned num;
    num = (k << shift) + n / 2;
    return 32'(num / n);
  endfunction

  task automatic cordic_sincos(input logic [31:0] ph, output longint s,
                               output longint c);
    logic [31:0] q, r;
    longint x, y, z, nx;
    q = ((ph + 32'h2000_0000) >> 30) & 32'd3;
    r = ph - (q << 30);
    z = longint'($signed(r));
    x = 652032874;
    y = 0;
    for (int k = 0; k < usg_pkg::CORDIC_STEPS; k++) begin
      if (z >= 0) begin
        nx = x - trunc_shift(y, k);
        y  = y + trunc_shift(x, k);
        z  = z - ATAN_PH[k];
      end else begin
        nx = x + trunc_shift(y, k);
        y  = y - trunc_shift(x, k);
        z  = z + ATAN_PH[k];
      end
      x = nx;
    end
    case (q)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic tile_vertex_t corner_vertex(longint sp, longint cp, longint st,
                                                 longint ct, logic last);
    tile_vertex_t t;
    longint px, pz;
    longint half_lim, unit_lim;
    px = sp * ct;
    pz = sp * st;
    half_lim = longint'(1) << (usg_pkg::FRAC_BITS - 1);
    unit_lim = longint'(1) << usg_pkg::FRAC_BITS;
    t.v.pos_x  = usg_pkg::POS_W'(clip(round_half_up(px, 61 - usg_pkg::FRAC_BITS),
                                      half_lim));
    t.v.pos_y  = usg_pkg::POS_W'(clip(round_half_up(cp, 31 - usg_pkg::FRAC_BITS),
                                      half_lim));
    t.v.pos_z  = usg_pkg::POS_W'(clip(round_half_up(pz, 61 - usg_pkg::FRAC_BITS),
                                      half_lim));
    t.v.norm_x = usg_pkg::NORM_W'(clip(round_half_up(px, 60 - usg_pkg::FRAC_BITS),
                                       unit_lim));
    t.v.norm_y = usg_pkg::NORM_W'(clip(round_half_up(cp, 30 - usg_pkg::FRAC_BITS),
                                       unit_lim));
    t.v.norm_z = usg_pkg::NORM_W'(clip(round_half_up(pz, 60 - usg_pkg::FRAC_BITS),
                                       unit_lim));
    t.last = last;
    return t;
  endfunction

  // Queue the six vertices of one tile in emission order TR, BR, BL, BL, TL, TR
  task automatic predict_tile_vertices(tile_t t);
    longint nb, nw, i, j;
    longint s0, c0, s1, c1, st0, ct0, st1, ct1;
    nb = band_regs;
    nw = wedge_regs;
    if (nb < 1) nb = 1;
    if (nb > usg_pkg::MAX_DIV) nb = usg_pkg::MAX_DIV;
    if (nw < 1) nw = 1;
    if (nw > usg_pkg::MAX_DIV) nw = usg_pkg::MAX_DIV;
    i = t.band;
    j = t.wedge;
    if (i >= nb) i = nb - 1;
    if (j >= nw) j = nw - 1;
    cordic_sincos(turn_phase(i, nb, usg_pkg::POLAR_SHIFT), s0, c0);
    cordic_sincos(turn_phase(i + 1, nb, usg_pkg::POLAR_SHIFT), s1, c1);
    cordic_sincos(turn_phase(j, nw, usg_pkg::AZ_SHIFT), st0, ct0);
    cordic_sincos(turn_phase(j + 1, nw, usg_pkg::AZ_SHIFT), st1, ct1);
    vertices_due = {vertices_due, corner_vertex(s0, c0, st1, ct1, 1'b0)};
    vertices_due = {vertices_due, corner_vertex(s1, c1, st1, ct1, 1'b0)};
    vertices_due = {vertices_due, corner_vertex(s1, c1, st0, ct0, 1'b0)};
    vertices_due = {vertices_due, corner_vertex(s1, c1, st0, ct0, 1'b0)};
    vertices_due = {vertices_due, corner_vertex(s0, c0, st0, ct0, 1'b0)};
    vertices_due = {vertices_due, corner_vertex(s0, c0, st1, ct1, 1'b1)};
  endtask

  // ---------------------------------------------------------------- clock, reset

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------- sender

  int burst_left = 0;
  int gap_left = 0;

  // Note acceptance at the edge; the driver looks at it on the next falling edge
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      predict_tile_vertices('{wedge: in_wedge_index, band: in_band_index});
      tiles_taken <= tiles_taken + 1;
    end
  end

  // Hold an offered item until taken, then advance through bursts and gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (tiles_pending.size() > 0) begin
      tile_t t;
      t = tiles_pending.pop_front();
      in_wedge_index <= t.wedge;
      in_band_index  <= t.band;
      in_valid       <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 20);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- receiver

  int  stall_mode = 0;
  int  mode_left = 0;
  int  long_hold_left = 0;
  bit  long_hold_done = 1'b0;

  // Stall on a mode that changes every stretch; once, hold off long enough
  // that the pipeline fills and in_ready drops while the sender keeps offering
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left <= long_hold_left - 1;
      out_ready <= 1'b0;
    end else if (!long_hold_done && tiles_taken >= 60) begin
      long_hold_done <= 1'b1;
      long_hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(10, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tile_vertex_t got, want;
      got.v.pos_x  = out_pos_x;
      got.v.pos_y  = out_pos_y;
      got.v.pos_z  = out_pos_z;
      got.v.norm_x = out_norm_x;
      got.v.norm_y = out_norm_y;
      got.v.norm_z = out_norm_z;
      got.last     = out_last_vertex;
      if (vertices_due.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected vertex pos=(%0d,%0d,%0d) norm=(%0d,%0d,%0d) last=%0b",
                   got.v.pos_x, got.v.pos_y, got.v.pos_z,
                   got.v.norm_x, got.v.norm_y, got.v.norm_z, got.last);
      end else begin
        want = vertices_due.pop_front();
        if (got !== want) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("vertex mismatch: expected pos=(%0d,%0d,%0d) norm=(%0d,%0d,%0d) last=%0b",
                     want.v.pos_x, want.v.pos_y, want.v.pos_z,
                     want.v.norm_x, want.v.norm_y, want.v.norm_z, want.last);
            $display("                 actual   pos=(%0d,%0d,%0d) norm=(%0d,%0d,%0d) last=%0b",
                     got.v.pos_x, got.v.pos_y, got.v.pos_z,
                     got.v.norm_x, got.v.norm_y, got.v.norm_z, got.last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Drain: no tile left to offer, none in flight, no vertex outstanding
  task automatic wait_idle();
    while (tiles_pending.size() > 0 || in_valid || vertices_due.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_count(usg_pkg::cfg_reg_t which, int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= usg_pkg::CNT_W'(value);
    @(posedge clk);
    if (which == usg_pkg::REG_BAND) band_regs = usg_pkg::CNT_W'(value);
    else wedge_regs = usg_pkg::CNT_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_counts(int bands, int wedges);
    wait_idle();
    write_count(usg_pkg::REG_BAND, bands);
    write_count(usg_pkg::REG_WEDGE, wedges);
  endtask

  task automatic add_tile(int wedge, int band);
    tile_t t;
    t.wedge = wedge[usg_pkg::IDX_W-1:0];
    t.band  = band[usg_pkg::IDX_W-1:0];
    tiles_pending = {tiles_pending, t};
  endtask

  // Mostly in-range tiles, a few clamped ones and some raw noise
  task automatic add_random_tiles(int n);
    int nb, nw;
    nb = (band_regs < 1) ? 1 :
         (band_regs > usg_pkg::MAX_DIV) ? usg_pkg::MAX_DIV : int'(band_regs);
    nw = (wedge_regs < 1) ? 1 :
         (wedge_regs > usg_pkg::MAX_DIV) ? usg_pkg::MAX_DIV : int'(wedge_regs);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: add_tile($urandom_range(0, 1023), $urandom_range(0, 1023));
        1: add_tile($urandom_range(nw - 1, 1023), $urandom_range(nb - 1, 1023));
        default: add_tile($urandom_range(0, nw - 1), $urandom_range(0, nb - 1));
      endcase
    end
  endtask

  initial begin
    int bands, wedges;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = usg_pkg::REG_BAND;
    cfg_data       = '0;
    band_regs      = usg_pkg::CNT_RESET;
    wedge_regs     = usg_pkg::CNT_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset counts: corners of the grid, the poles, and clamped indices
    add_tile(0, 0);
    add_tile(15, 15);
    add_tile(0, 15);
    add_tile(15, 0);
    add_tile(7, 8);
    add_tile(16, 16);
    add_tile(1023, 1023);
    add_tile(512, 3);

    // Single band and wedge: the whole sphere is one tile
    set_counts(1, 1);
    add_tile(0, 0);
    add_tile(1023, 1023);
    add_tile(1, 0);

    // Largest counts: finest steps, last tile meets the south pole
    set_counts(usg_pkg::MAX_DIV, usg_pkg::MAX_DIV);
    add_tile(0, 0);
    add_tile(1023, 1023);
    add_tile(511, 512);
    add_tile(682, 341);

    // Counts outside 1..1024 are clamped by the block
    set_counts(0, 2047);
    add_tile(0, 0);
    add_tile(1023, 5);
    set_counts(2047, 0);
    add_tile(0, 1023);
    add_tile(300, 700);
    set_counts(1025, 3);
    add_tile(2, 1024 - 1);
    add_tile(3, 0);

    // Random phases, mostly small counts, a few at the top end
    for (int p = 0; p < 9; p++) begin
      case ($urandom_range(0, 4))
        0: begin bands = $urandom_range(1, 2047); wedges = $urandom_range(1, 2047); end
        default: begin bands = $urandom_range(1, 40); wedges = $urandom_range(1, 40); end
      endcase
      if (p == 8) begin bands = usg_pkg::MAX_DIV; wedges = 2; end
      set_counts(bands, wedges);
      add_random_tiles(37);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
